// File: design/text_console_cursor_scroll_unit_assert.svh
// ----------------------------------------------------------------------------
// Text console assertion macros
// Shared property forms for the console checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_UNIT_ASSERT_SVH

// same-cycle implication
`define TCCS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCCS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tccs_pkg.sv
// ----------------------------------------------------------------------------
// Text console package
// Shared constants, codes, result type and cell packing.
// ----------------------------------------------------------------------------
package tccs_pkg;

  localparam int SCREEN_WIDTH_DEF  = 80;
  localparam int SCREEN_HEIGHT_DEF = 25;

  localparam int CELL_W      = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 4;
  localparam int IN_W        = 24;
  localparam int OUT_W       = 32;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_FG = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BG = 1'd1;

  localparam logic [3:0] FG_RESET = 4'd15;
  localparam logic [3:0] BG_RESET = 4'd0;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_BLANK   = 8'h20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCROLL,
    ST_DRAIN,
    ST_FILL,
    ST_PUT,
    ST_CLEAR,
    ST_READ
  } state_t;

  typedef struct packed {
    logic        scrolled;
    logic [15:0] cell_data;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
  } res_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [7:0] attr,
                                                  input logic [7:0] ch);
    make_cell = {attr, ch};
  endfunction

endpackage

// File: design/tccs_ram.sv
// ----------------------------------------------------------------------------
// Text console screen memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tccs_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/tccs_ctrl.sv
// ----------------------------------------------------------------------------
// Text console sequencer
// Cursor, command decode and sweeps over the screen memory.
// ----------------------------------------------------------------------------
module tccs_ctrl #(
  parameter int SCREEN_WIDTH  = tccs_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tccs_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [1:0]                             cmd,
  input  logic [7:0]                             char_code,
  input  logic [10:0]                            cell_index,
  input  logic [7:0]                             attr,
  output logic                                   idle,
  output logic                                   done,
  output tccs_pkg::res_t                         res,
  output logic                                   mem_we,
  output logic [$clog2(SCREEN_WIDTH*SCREEN_HEIGHT)-1:0] mem_waddr,
  output logic [tccs_pkg::CELL_W-1:0]            mem_wdata,
  output logic                                   mem_re,
  output logic [$clog2(SCREEN_WIDTH*SCREEN_HEIGHT)-1:0] mem_raddr,
  input  logic [tccs_pkg::CELL_W-1:0]            mem_rdata
);

  localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
  localparam int COL_W  = $clog2(SCREEN_WIDTH + 1);

  localparam logic [ADDR_W-1:0] W_A       = ADDR_W'(SCREEN_WIDTH);
  localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH - 1);
  localparam logic [ADDR_W-1:0] BOT_A     = ADDR_W'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH);
  localparam logic [ADDR_W-1:0] LAST_A    = ADDR_W'(CELLS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(SCREEN_HEIGHT - 1);
  localparam logic [COL_W-1:0]  COL_END   = COL_W'(SCREEN_WIDTH);

  tccs_pkg::state_t state, state_next;

  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] copy_addr;
  logic [7:0]        ch;
  logic              put_pend;
  logic              scr;
  logic              copy_pend;

  logic              is_nl;
  logic              wrap;
  logic              at_bottom;
  logic              idx_ok;
  logic [ROW_W-1:0]  row_inc;
  logic [COL_W-1:0]  col_inc;
  logic [ADDR_W-1:0] cur_addr;
  logic [tccs_pkg::CELL_W-1:0] blank;

  assign is_nl     = (char_code == tccs_pkg::CHAR_NEWLINE);
  assign wrap      = (col == COL_END);
  assign at_bottom = (row == ROW_LAST);
  assign idx_ok    = (32'(cell_index) < 32'(CELLS));
  assign row_inc   = row + 1'b1;
  assign col_inc   = col + 1'b1;
  assign cur_addr  = ADDR_W'(row) * W_A + ADDR_W'(col);
  assign blank     = tccs_pkg::make_cell(attr, tccs_pkg::CHAR_BLANK);
  assign idle      = (state == tccs_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      tccs_pkg::ST_IDLE: begin
        if (start) begin
          case (cmd)
            tccs_pkg::CMD_PUT: begin
              if ((is_nl || wrap) && at_bottom) begin
                state_next = tccs_pkg::ST_SCROLL;
              end else if (!is_nl && wrap) begin
                state_next = tccs_pkg::ST_PUT;
              end
            end
            tccs_pkg::CMD_CLEAR: state_next = tccs_pkg::ST_CLEAR;
            tccs_pkg::CMD_READ: begin
              if (idx_ok) begin
                state_next = tccs_pkg::ST_READ;
              end
            end
            default: state_next = tccs_pkg::ST_IDLE;
          endcase
        end
      end
      tccs_pkg::ST_SCROLL: begin
        if (cnt == COPY_LAST) begin
          state_next = tccs_pkg::ST_DRAIN;
        end
      end
      tccs_pkg::ST_DRAIN: state_next = tccs_pkg::ST_FILL;
      tccs_pkg::ST_FILL: begin
        if (cnt == LAST_A) begin
          state_next = put_pend ? tccs_pkg::ST_PUT : tccs_pkg::ST_IDLE;
        end
      end
      tccs_pkg::ST_PUT: state_next = tccs_pkg::ST_IDLE;
      tccs_pkg::ST_CLEAR: begin
        if (cnt == LAST_A) begin
          state_next = tccs_pkg::ST_IDLE;
        end
      end
      tccs_pkg::ST_READ: state_next = tccs_pkg::ST_IDLE;
      default: state_next = tccs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we         = 1'b0;
    mem_waddr      = cur_addr;
    mem_wdata      = blank;
    mem_re         = 1'b0;
    mem_raddr      = cnt + W_A;
    done           = 1'b0;
    res            = '0;
    res.cursor_row = 5'(row);
    res.cursor_col = 7'(col);
    if (copy_pend) begin
      mem_we    = 1'b1;
      mem_waddr = copy_addr;
      mem_wdata = mem_rdata;
    end
    case (state)
      tccs_pkg::ST_IDLE: begin
        if (start) begin
          case (cmd)
            tccs_pkg::CMD_PUT: begin
              if (!is_nl && !wrap) begin
                mem_we         = 1'b1;
                mem_wdata      = tccs_pkg::make_cell(attr, char_code);
                done           = 1'b1;
                res.cursor_col = 7'(col_inc);
              end else if (is_nl && !at_bottom) begin
                done           = 1'b1;
                res.cursor_row = 5'(row_inc);
                res.cursor_col = '0;
              end
            end
            tccs_pkg::CMD_CLEAR: done = 1'b0;
            tccs_pkg::CMD_READ: begin
              if (idx_ok) begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(cell_index);
              end else begin
                done = 1'b1;
              end
            end
            default: done = 1'b1;
          endcase
        end
      end
      tccs_pkg::ST_SCROLL: mem_re = 1'b1;
      tccs_pkg::ST_DRAIN: mem_re = 1'b0;
      tccs_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        mem_wdata = blank;
        if (cnt == LAST_A && !put_pend) begin
          done         = 1'b1;
          res.scrolled = 1'b1;
        end
      end
      tccs_pkg::ST_PUT: begin
        mem_we         = 1'b1;
        mem_wdata      = tccs_pkg::make_cell(attr, ch);
        done           = 1'b1;
        res.cursor_col = 7'(col_inc);
        res.scrolled   = scr;
      end
      tccs_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        mem_wdata = blank;
        if (cnt == LAST_A) begin
          done = 1'b1;
        end
      end
      tccs_pkg::ST_READ: begin
        done          = 1'b1;
        res.cell_data = mem_rdata;
      end
      default: done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tccs_pkg::ST_IDLE;
      row       <= '0;
      col       <= '0;
      put_pend  <= 1'b0;
      scr       <= 1'b0;
      copy_pend <= 1'b0;
    end else begin
      state     <= state_next;
      copy_pend <= (state == tccs_pkg::ST_SCROLL);
      case (state)
        tccs_pkg::ST_IDLE: begin
          if (start) begin
            case (cmd)
              tccs_pkg::CMD_PUT: begin
                if (!is_nl && !wrap) begin
                  col <= col_inc;
                end else begin
                  col      <= '0;
                  put_pend <= !is_nl;
                  if (at_bottom) begin
                    scr <= 1'b1;
                  end else begin
                    row <= row_inc;
                    scr <= 1'b0;
                  end
                end
              end
              tccs_pkg::CMD_CLEAR: begin
                row <= '0;
                col <= '0;
              end
              default: row <= row;
            endcase
          end
        end
        tccs_pkg::ST_PUT: col <= col_inc;
        default: col <= col;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      tccs_pkg::ST_IDLE: begin
        cnt <= '0;
        if (start) begin
          ch <= char_code;
        end
      end
      tccs_pkg::ST_SCROLL: begin
        copy_addr <= cnt;
        cnt       <= (cnt == COPY_LAST) ? BOT_A : cnt + 1'b1;
      end
      tccs_pkg::ST_FILL:  cnt <= cnt + 1'b1;
      tccs_pkg::ST_CLEAR: cnt <= cnt + 1'b1;
      default:            cnt <= cnt;
    endcase
  end

endmodule

// File: design/text_console_cursor_scroll_unit.sv
// ----------------------------------------------------------------------------
// Text console with cursor and scroll
// Words enter on the s_ group (cmd, char_code, cell_index) and one result
// word per input leaves on the m_ group through an output register. A new
// word is taken only while the sequencer is idle and the output register is
// empty or being drained. A plain character, a newline without scroll, an
// unused command and a bad index finish straight from idle; a character
// after a pending wrap goes through the put state, a cell read through the
// read state. A scroll copies rows up, drains and blanks the bottom row
// (then puts the character); a clear blanks every cell. Scroll and clear
// walk the single screen memory one cell per cycle; the memory's one write
// port sets this pace. Reset homes the cursor, loads the default colors and
// empties the output register; the screen memory is not cleared. A stalled
// receiver holds the result and blocks new input.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_unit #(
  parameter int SCREEN_WIDTH  = tccs_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tccs_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [tccs_pkg::IN_W-1:0]           s_tdata,   // cmd, char_code, cell_index
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tccs_pkg::OUT_W-1:0]          m_tdata,   // cursor_row, cursor_col,
                                                         // cell_data, scrolled
  input  logic                                cfg_we,
  input  logic [tccs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tccs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W = $clog2(CELLS);

  logic [3:0]                  fg_color;
  logic [3:0]                  bg_color;
  logic                        start;
  logic                        idle;
  logic                        done;
  tccs_pkg::res_t              res;
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [tccs_pkg::CELL_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [ADDR_W-1:0]           mem_raddr;
  logic [tccs_pkg::CELL_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= tccs_pkg::FG_RESET;
      bg_color <= tccs_pkg::BG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tccs_pkg::REG_FG: fg_color <= cfg_data;
        tccs_pkg::REG_BG: bg_color <= cfg_data;
        default:          fg_color <= fg_color;
      endcase
    end
  end

  assign s_tready = idle && (!m_tvalid || m_tready);
  assign start    = s_tvalid && s_tready;

  tccs_ctrl #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (s_tdata[1:0]),
    .char_code  (s_tdata[9:2]),
    .cell_index (s_tdata[20:10]),
    .attr       ({bg_color, fg_color}),
    .idle       (idle),
    .done       (done),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  tccs_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W),
    .DATA_W (tccs_pkg::CELL_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= {3'b000, res};
    end
  end

endmodule

// File: design/tccs_checker.sv
// ----------------------------------------------------------------------------
// Text console port checker
// Watches the stream ports of the console over time.
// ----------------------------------------------------------------------------
`include "text_console_cursor_scroll_unit_assert.svh"

module tccs_checker #(
  parameter int SCREEN_WIDTH  = tccs_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tccs_pkg::SCREEN_HEIGHT_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [tccs_pkg::OUT_W-1:0] m_tdata
);

  localparam int ROW_LAST = SCREEN_HEIGHT - 1;

  `TCCS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata), "result word dropped or changed while stalled")

  `TCCS_ASSERT_SAME(a_no_accept_full, clk, rst, s_tready && m_tvalid,
    m_tready, "input taken while output register full")

  `TCCS_ASSERT_SAME(a_scroll_bottom, clk, rst, m_tvalid && m_tdata[28],
    (32'(m_tdata[4:0]) == ROW_LAST) && (m_tdata[11:5] <= 7'd1),
    "scroll result with cursor off the bottom row start")

  `TCCS_ASSERT_SAME(a_row_range, clk, rst, m_tvalid,
    (32'(m_tdata[4:0]) <= ROW_LAST) && (32'(m_tdata[11:5]) <= SCREEN_WIDTH),
    "cursor past the screen")

endmodule

bind text_console_cursor_scroll_unit tccs_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: tb/text_console_cursor_scroll_unit_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console checker
// Watches the input, output and register write ports of the console. It keeps
// its own screen image, cursor and colors, and works out the status word that
// each accepted input word must produce. Every output word is compared field
// by field with the oldest expected one. The failure count and the number of
// status words still due go to the top.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_unit_chk #(
  parameter int SCREEN_WIDTH  = tccs_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tccs_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [tccs_pkg::IN_W-1:0]        s_tdata,   // cmd, char_code, cell_index
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [tccs_pkg::OUT_W-1:0]       m_tdata,   // cursor_row, cursor_col,
                                                      // cell_data, scrolled
  input  logic                             cfg_we,
  input  logic [tccs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tccs_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               fail_count,
  output int                               pending
);

  localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;

  logic [tccs_pkg::CELL_W-1:0] screen [CELLS];
  int                          cur_row;
  int                          cur_col;
  logic [3:0]                  fg;
  logic [3:0]                  bg;
  tccs_pkg::res_t              status_due [$];
  tccs_pkg::res_t              seen;
  tccs_pkg::res_t              want;

  function automatic logic [tccs_pkg::CELL_W-1:0] colored(input logic [7:0] ch);
    return {bg, fg, ch};
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - SCREEN_WIDTH; i++) begin
      screen[i] = screen[i + SCREEN_WIDTH];
    end
    for (int i = CELLS - SCREEN_WIDTH; i < CELLS; i++) begin
      screen[i] = colored(tccs_pkg::CHAR_BLANK);
    end
  endfunction

  function automatic logic advance_row();
    cur_col = 0;
    cur_row++;
    if (cur_row >= SCREEN_HEIGHT) begin
      scroll_screen();
      cur_row = SCREEN_HEIGHT - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic tccs_pkg::res_t console_step(input logic [1:0] cmd,
                                                  input logic [7:0] ch,
                                                  input logic [10:0] idx);
    tccs_pkg::res_t r;
    int             pos;
    r = '0;
    case (cmd)
      tccs_pkg::CMD_PUT: begin
        if (ch == tccs_pkg::CHAR_NEWLINE) begin
          r.scrolled = advance_row();
        end else begin
          if (cur_col >= SCREEN_WIDTH) r.scrolled = advance_row();
          if (cur_row >= SCREEN_HEIGHT) cur_row = SCREEN_HEIGHT - 1;
          pos = cur_row * SCREEN_WIDTH + cur_col;
          if (pos < CELLS) screen[pos] = colored(ch);
          cur_col++;
        end
      end
      tccs_pkg::CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = colored(tccs_pkg::CHAR_BLANK);
        cur_row = 0;
        cur_col = 0;
      end
      tccs_pkg::CMD_READ: begin
        if (int'(idx) < CELLS) r.cell_data = screen[idx];
      end
      default: ;
    endcase
    r.cursor_row = cur_row[4:0];
    r.cursor_col = cur_col[6:0];
    return r;
  endfunction

  function automatic bit field_ok(input string name, input int exp_val, input int got_val);
    if (exp_val == got_val) return 1'b1;
    $display("%0t: %s expected %0d got %0d", $time, name, exp_val, got_val);
    return 1'b0;
  endfunction

  initial begin
    for (int i = 0; i < CELLS; i++) screen[i] = '0;
  end

  always @(posedge clk) begin
    if (rst) begin
      status_due.delete();
      cur_row    = 0;
      cur_col    = 0;
      fg         = tccs_pkg::FG_RESET;
      bg         = tccs_pkg::BG_RESET;
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tccs_pkg::REG_FG: fg = cfg_data;
          tccs_pkg::REG_BG: bg = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        status_due.push_back(console_step(s_tdata[1:0], s_tdata[9:2], s_tdata[20:10]));
      if (m_tvalid && m_tready) begin
        seen = m_tdata[28:0];
        if (status_due.size() == 0) begin
          $display("%0t: status word with none expected, got %h", $time, m_tdata);
          fail_count++;
        end else begin
          want = status_due.pop_front();
          if (!(field_ok("cursor_row", int'(want.cursor_row), int'(seen.cursor_row)) &
                field_ok("cursor_col", int'(want.cursor_col), int'(seen.cursor_col)) &
                field_ok("cell_data", int'(want.cell_data), int'(seen.cell_data)) &
                field_ok("scrolled", int'(want.scrolled), int'(seen.scrolled))))
            fail_count++;
        end
      end
    end
    pending = status_due.size();
  end

endmodule

// File: tb/text_console_cursor_scroll_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console testbench
// Drives the console with a short directed sequence and then with random text:
// runs of newlines, short lines, lines that wrap up to three times, cell reads,
// clears and unused commands, over several color settings. Both stream sides
// idle at random, and the receiver once holds off long enough to stall input.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_unit_tb;

  localparam logic [1:0] CMD_NOP   = 2'd3;
  localparam int CELLS           = tccs_pkg::SCREEN_WIDTH_DEF * tccs_pkg::SCREEN_HEIGHT_DEF;
  localparam int IDX_MAX         = 2047;
  localparam int RESET_CYCLES    = 7;
  localparam int PHASES          = 6;
  localparam int PHASE_ITEMS     = 210;
  localparam int PRESSURE_AT     = 500;
  localparam int PRESSURE_CYCLES = 600;
  localparam int DRAIN_CYCLES    = 16;
  localparam int WATCHDOG_LIMIT  = 20000;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             s_tvalid  = 1'b0;
  logic                             s_tready;
  logic [tccs_pkg::IN_W-1:0]        s_tdata   = '0;
  logic                             m_tvalid;
  logic                             m_tready  = 1'b0;
  logic [tccs_pkg::OUT_W-1:0]       m_tdata;
  logic                             cfg_we    = 1'b0;
  logic [tccs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [tccs_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
  int                               fail_count;
  int                               pending;

  int words_sent    = 0;
  int src_mode      = 0;
  int src_left      = 0;
  int snk_mode      = 0;
  int snk_left      = 0;
  int hold_left     = 0;
  bit pressure_done = 1'b0;
  int idle_cycles   = 0;

  text_console_cursor_scroll_unit u_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .cfg_we, .cfg_index, .cfg_data
  );

  text_console_cursor_scroll_unit_chk u_chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .cfg_we, .cfg_index, .cfg_data, .fail_count, .pending
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [tccs_pkg::IN_W-1:0] pack_word(input logic [1:0] cmd,
                                                          input logic [7:0] ch,
                                                          input logic [10:0] idx);
    return {3'b000, idx, ch, cmd};
  endfunction

  function automatic logic [10:0] rand_index();
    return 11'($urandom_range(0, IDX_MAX));
  endfunction

  function automatic logic [7:0] rand_char();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [10:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 11'($urandom_range(0, CELLS - 1));
    if (r < 70) return 11'($urandom_range(CELLS - tccs_pkg::SCREEN_WIDTH_DEF, CELLS - 1));
    if (r < 85) return 11'($urandom_range(0, tccs_pkg::SCREEN_WIDTH_DEF - 1));
    return rand_index();
  endfunction

  task automatic send_word(input logic [tccs_pkg::IN_W-1:0] w);
    int gap;
    if (src_left == 0) begin
      src_mode = $urandom_range(0, 2);
      src_left = $urandom_range(20, 80);
    end
    src_left--;
    case (src_mode)
      0: gap = 0;
      1: gap = ($urandom_range(0, 99) < 40) ? $urandom_range(1, 3) : 0;
      default: gap = ($urandom_range(0, 99) < 8) ? $urandom_range(10, 60)
                                                  : $urandom_range(0, 1);
    endcase
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic cfg_write(input logic [tccs_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [3:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_text(input int target);
    int done_items;
    int r;
    int len;
    int puts;
    done_items = 0;
    while (done_items < target) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        len = $urandom_range(5, 30);
        repeat (len) send_word(pack_word(tccs_pkg::CMD_PUT, tccs_pkg::CHAR_NEWLINE,
                                         rand_index()));
        done_items += len;
      end else if (r < 95) begin
        if (r < 65) len = $urandom_range(0, 20);
        else if (r < 87) len = $urandom_range(76, 90);
        else len = $urandom_range(150, 250);
        puts = 0;
        while (puts < len && done_items < target) begin
          r = $urandom_range(0, 99);
          if (r < 18) begin
            send_word(pack_word(tccs_pkg::CMD_READ, rand_char(), pick_index()));
            done_items++;
          end else if (r < 20) begin
            send_word(pack_word(CMD_NOP, rand_char(), rand_index()));
          end else begin
            send_word(pack_word(tccs_pkg::CMD_PUT, rand_char(), rand_index()));
            done_items++;
            puts++;
          end
        end
        if ($urandom_range(0, 99) < 75) begin
          send_word(pack_word(tccs_pkg::CMD_PUT, tccs_pkg::CHAR_NEWLINE, rand_index()));
          done_items++;
        end
      end else begin
        send_word(pack_word(tccs_pkg::CMD_CLEAR, rand_char(), rand_index()));
        done_items++;
      end
    end
  endtask

  initial begin
    logic [3:0] fg_val;
    logic [3:0] bg_val;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    send_word(pack_word(tccs_pkg::CMD_CLEAR, 8'hFF, 11'(IDX_MAX)));
    send_word(pack_word(tccs_pkg::CMD_READ, 8'h00, 11'd0));
    send_word(pack_word(tccs_pkg::CMD_READ, 8'hFF, 11'(CELLS - 1)));
    send_word(pack_word(tccs_pkg::CMD_READ, 8'h00, 11'(CELLS)));
    send_word(pack_word(tccs_pkg::CMD_READ, 8'h00, 11'(IDX_MAX)));
    send_word(pack_word(CMD_NOP, 8'hFF, 11'(IDX_MAX)));
    send_word(pack_word(CMD_NOP, 8'h00, 11'd0));
    send_word(pack_word(tccs_pkg::CMD_PUT, 8'h00, 11'd0));
    send_word(pack_word(tccs_pkg::CMD_PUT, 8'hFF, 11'(IDX_MAX)));
    send_word(pack_word(tccs_pkg::CMD_PUT, tccs_pkg::CHAR_BLANK, 11'd0));
    send_word(pack_word(tccs_pkg::CMD_PUT, tccs_pkg::CHAR_NEWLINE, 11'(IDX_MAX)));
    send_word(pack_word(tccs_pkg::CMD_PUT, 8'h41, 11'd0));
    send_word(pack_word(tccs_pkg::CMD_READ, 8'h00, 11'd0));
    send_word(pack_word(tccs_pkg::CMD_READ, 8'h00, 11'd1));
    send_word(pack_word(tccs_pkg::CMD_READ, 8'h00, 11'd2));
    send_word(pack_word(tccs_pkg::CMD_READ, 8'h00, 11'(tccs_pkg::SCREEN_WIDTH_DEF)));
    settle();

    for (int k = 0; k < PHASES; k++) begin
      fg_val = (k % 2 == 0) ? 4'd0 : 4'd15;
      bg_val = (k < 2) ? 4'd15 : 4'd0;
      if (k >= 4) begin
        fg_val = 4'($urandom_range(0, 15));
        bg_val = 4'($urandom_range(0, 15));
      end
      cfg_write(tccs_pkg::REG_FG, fg_val);
      cfg_write(tccs_pkg::REG_BG, bg_val);
      run_text(PHASE_ITEMS);
      settle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (!pressure_done && words_sent >= PRESSURE_AT) begin
      pressure_done = 1'b1;
      hold_left     = PRESSURE_CYCLES - 1;
      m_tready     <= 1'b0;
    end else begin
      if (snk_left == 0) begin
        snk_mode = $urandom_range(0, 2);
        snk_left = $urandom_range(100, 400);
      end
      snk_left--;
      case (snk_mode)
        0: m_tready <= 1'b1;
        1: begin
          if ($urandom_range(0, 99) < 25) begin
            m_tready <= 1'b0;
            hold_left = $urandom_range(0, 2);
          end else begin
            m_tready <= 1'b1;
          end
        end
        default: begin
          if ($urandom_range(0, 99) < 3) begin
            m_tready <= 1'b0;
            hold_left = $urandom_range(20, 80);
          end else begin
            m_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule

// File: text_console_cursor_scroll_unit.f
+incdir+design
design/tccs_pkg.sv
design/tccs_ram.sv
design/tccs_ctrl.sv
design/text_console_cursor_scroll_unit.sv
design/tccs_checker.sv
tb/text_console_cursor_scroll_unit_chk.sv
tb/text_console_cursor_scroll_unit_tb.sv
